// ----- hdl/iasa_pkg.sv -----
package iasa_pkg;

   // Default sizing of the group table, the slot lists and the pass counters.
   localparam int GROUPS_DEF          = 16;
   localparam int SLOTS_PER_GROUP_DEF = 8;
   localparam int PASS_BITS_DEF       = 16;

   // Operation codes carried by an input beat.
   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Status codes carried by a result beat.
   localparam logic [2:0] ST_REUSED      = 3'd0;
   localparam logic [2:0] ST_NEW         = 3'd1;
   localparam logic [2:0] ST_SKIP        = 3'd2;
   localparam logic [2:0] ST_GROUPS_FULL = 3'd3;
   localparam logic [2:0] ST_SLOTS_FULL  = 3'd4;

   // One input beat.
   typedef struct packed {
      logic        operation;
      logic [63:0] group_key;
      logic [15:0] first_pass;
      logic [15:0] last_pass;
      logic        allocate;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [2:0] slot;
      logic [2:0] status;
   } rsp_type;

endpackage

// ----- hdl/iasa_ram.sv -----
module iasa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/interval_alias_slot_assigner_core.sv -----
// First-fit alias slot assigner for render pass resources.
//
// Input beats arrive on req_valid / req_ready / req_data. A clear beat forgets
// every group; an assign beat names a group key, a first and last pass and an
// allocate flag. Each input beat gives exactly one result beat on
// rsp_valid / rsp_ready / rsp_data, carrying the slot and a status code.
//
// Sequence from the accepting edge to the load of the result register: a clear
// or a skipped entry goes straight to the hand-off state. An allocated entry
// sweeps the tag memory one row a cycle, then the group's slots one slot a
// cycle, through a single compare path on registered read data, and then hands
// off the result. A new group has no slots to compare and takes a new slot; a
// full table skips the slot sweep. req_ready is high only in the idle state.
//
// The result sits in an output register, so the next beat may be accepted
// while an earlier result waits on a stalled receiver; that beat then holds
// its own result until the register frees up.
// Reset drops every group at once; tag and pass memories need no sweep.
module interval_alias_slot_assigner_core #(
   parameter int GROUPS          = iasa_pkg::GROUPS_DEF,
   parameter int SLOTS_PER_GROUP = iasa_pkg::SLOTS_PER_GROUP_DEF,
   parameter int PASS_BITS       = iasa_pkg::PASS_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iasa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output iasa_pkg::rsp_type rsp_data
);

   localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int GCNT_W = $clog2(GROUPS + 1);
   localparam int SIDX_W = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
   localparam int SCNT_W = $clog2(SLOTS_PER_GROUP + 1);
   localparam int SDEPTH = GROUPS * SLOTS_PER_GROUP;
   localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_GSCAN = 2'd1;
   localparam logic [1:0] S_SSCAN = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [GROUPS-1:0]       valid_ff, valid_in;
   logic [SCNT_W-1:0]       cnt_ff [GROUPS];
   logic [SCNT_W-1:0]       cnt_in [GROUPS];

   // Captured entry.
   logic [63:0]             key_ff, key_in;
   logic [PASS_BITS-1:0]    first_ff, first_in;
   logic [PASS_BITS-1:0]    last_ff, last_in;

   // Group sweep.
   logic [GCNT_W-1:0]       gscan_ff, gscan_in;
   logic                    gpend_ff, gpend_in;
   logic [GIDX_W-1:0]       gpidx_ff, gpidx_in;
   logic                    free_found_ff, free_found_in;
   logic [GIDX_W-1:0]       free_ff, free_in;
   logic [GIDX_W-1:0]       grp_ff, grp_in;

   // Slot sweep.
   logic [SCNT_W-1:0]       sscan_ff, sscan_in;
   logic                    spend_ff, spend_in;
   logic [SIDX_W-1:0]       spidx_ff, spidx_in;
   logic [SCNT_W-1:0]       nslot_ff, nslot_in;

   // Pending result and output register.
   iasa_pkg::rsp_type       res_ff, res_in;
   iasa_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Memory ports.
   logic                    tag_wr_en;
   logic [GIDX_W-1:0]       tag_rd_addr;
   logic [63:0]             tag_rd_data;
   logic                    sl_wr_en;
   logic [SA_W-1:0]         sl_wr_addr;
   logic [SA_W-1:0]         sl_rd_addr;
   logic [PASS_BITS-1:0]    sl_rd_data;
   logic [SA_W-1:0]         sl_base;

   logic [31:0]             first_wide;
   logic [31:0]             last_wide;
   logic [31:0]             spidx_wide;
   logic [31:0]             nslot_wide;
   logic                    out_free;

   // Pass fields zero-extended, then taken to the pass counter width.
   assign first_wide = {16'd0, req_data.first_pass};
   assign last_wide  = {16'd0, req_data.last_pass};
   assign spidx_wide = 32'(spidx_ff);
   assign nslot_wide = 32'(nslot_ff);

   assign sl_base  = SA_W'(grp_ff) * SA_W'(SLOTS_PER_GROUP);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   iasa_ram #(
      .WIDTH (64),
      .DEPTH (GROUPS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (free_ff),
      .wr_data (key_ff),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   iasa_ram #(
      .WIDTH (PASS_BITS),
      .DEPTH (SDEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (sl_wr_en),
      .wr_addr (sl_wr_addr),
      .wr_data (last_ff),
      .rd_addr (sl_rd_addr),
      .rd_data (sl_rd_data)
   );

   // Sequencer: capture, group sweep, slot sweep, result hand-off.
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      gscan_in      = gscan_ff;
      gpend_in      = gpend_ff;
      gpidx_in      = gpidx_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      grp_in        = grp_ff;
      sscan_in      = sscan_ff;
      spend_in      = spend_ff;
      spidx_in      = spidx_ff;
      nslot_in      = nslot_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      tag_wr_en     = 1'b0;
      tag_rd_addr   = gscan_ff[GIDX_W-1:0];
      sl_wr_en      = 1'b0;
      sl_wr_addr    = sl_base + SA_W'(spidx_ff);
      sl_rd_addr    = sl_base + SA_W'(sscan_ff[SIDX_W-1:0]);

      // The output register drains whenever the receiver takes its beat.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in        = req_data.group_key;
               first_in      = first_wide[PASS_BITS-1:0];
               last_in       = last_wide[PASS_BITS-1:0];
               gscan_in      = '0;
               gpend_in      = 1'b0;
               free_found_in = 1'b0;
               res_in.slot   = 3'd0;
               res_in.status = iasa_pkg::ST_SKIP;
               if (req_data.operation == iasa_pkg::OP_CLEAR) begin
                  valid_in = '0;
                  for (int g = 0; g < GROUPS; g++) begin
                     cnt_in[g] = '0;
                  end
                  state_in = S_EMIT;
               end else if (!req_data.allocate) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_GSCAN;
               end
            end
         end

         S_GSCAN: begin
            // Issue the next row while comparing the one read last cycle.
            gpend_in = (gscan_ff < GCNT_W'(GROUPS));
            gpidx_in = gscan_ff[GIDX_W-1:0];
            if (gscan_ff < GCNT_W'(GROUPS)) begin
               gscan_in = gscan_ff + 1'b1;
            end
            if (gpend_ff) begin
               if (valid_ff[gpidx_ff] && (tag_rd_data == key_ff)) begin
                  grp_in   = gpidx_ff;
                  nslot_in = cnt_ff[gpidx_ff];
                  sscan_in = '0;
                  spend_in = 1'b0;
                  state_in = S_SSCAN;
               end else if (!valid_ff[gpidx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = gpidx_ff;
               end
            end else if (gscan_ff >= GCNT_W'(GROUPS)) begin
               // Sweep done without a match: open the first free row, or report a full table.
               if (free_found_ff) begin
                  tag_wr_en         = 1'b1;
                  valid_in[free_ff] = 1'b1;
                  cnt_in[free_ff]   = '0;
                  grp_in            = free_ff;
                  nslot_in          = '0;
                  sscan_in          = '0;
                  spend_in          = 1'b0;
                  state_in          = S_SSCAN;
               end else begin
                  res_in.slot   = 3'd0;
                  res_in.status = iasa_pkg::ST_GROUPS_FULL;
                  state_in      = S_EMIT;
               end
            end
         end

         S_SSCAN: begin
            // Same overlap over the group's slots in creation order.
            spend_in = (sscan_ff < nslot_ff);
            spidx_in = sscan_ff[SIDX_W-1:0];
            if (sscan_ff < nslot_ff) begin
               sscan_in = sscan_ff + 1'b1;
            end
            if (spend_ff) begin
               if (sl_rd_data < first_ff) begin
                  sl_wr_en      = 1'b1;
                  res_in.slot   = spidx_wide[2:0];
                  res_in.status = iasa_pkg::ST_REUSED;
                  state_in      = S_EMIT;
               end
            end else if (sscan_ff >= nslot_ff) begin
               if (nslot_ff >= SCNT_W'(SLOTS_PER_GROUP)) begin
                  res_in.slot   = 3'd0;
                  res_in.status = iasa_pkg::ST_SLOTS_FULL;
               end else begin
                  sl_wr_en       = 1'b1;
                  sl_wr_addr     = sl_base + SA_W'(nslot_ff[SIDX_W-1:0]);
                  cnt_in[grp_ff] = nslot_ff + 1'b1;
                  res_in.slot    = nslot_wide[2:0];
                  res_in.status  = iasa_pkg::ST_NEW;
               end
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state is reset; captured payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GROUPS; g++) begin
            cnt_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      key_ff        <= key_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      gscan_ff      <= gscan_in;
      gpend_ff      <= gpend_in;
      gpidx_ff      <= gpidx_in;
      free_found_ff <= free_found_in;
      free_ff       <= free_in;
      grp_ff        <= grp_in;
      sscan_ff      <= sscan_in;
      spend_ff      <= spend_in;
      spidx_ff      <= spidx_in;
      nslot_ff      <= nslot_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   // A beat taken in is followed by a busy cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block still ready after accepting a beat");

   // Only reuse and new-slot results name a slot.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != iasa_pkg::ST_REUSED)
                 && (rsp_data.status != iasa_pkg::ST_NEW)) |-> (rsp_data.slot == 3'd0))
      else $error("slot given with a status that assigns none");

   // A group never holds more slots than its list allows.
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SSCAN) |-> (nslot_ff <= SCNT_W'(SLOTS_PER_GROUP)))
      else $error("slot count beyond the list size");

   // A tag is written only into a row that was free during the sweep.
   a_tag_free_row: assert property (@(posedge clock) disable iff (reset)
      tag_wr_en |-> (free_found_ff && !valid_ff[free_ff] && (state_ff == S_GSCAN)))
      else $error("group opened over a live row");

   // A result is loaded only when the output register can take it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("pending result overwritten");

endmodule
